// ----- rtl/tgc_pkg.sv -----
// Package for the touch gesture classifier: event modes, gesture and error codes, payload types.
// No dependencies.
`default_nettype none
package tgc_pkg;
  localparam logic [1:0] MODE_DOWN   = 2'd0;
  localparam logic [1:0] MODE_UP     = 2'd1;
  localparam logic [1:0] MODE_MOTION = 2'd2;

  localparam logic [2:0] GK_TAP       = 3'd0;
  localparam logic [2:0] GK_LONG_TAP  = 3'd1;
  localparam logic [2:0] GK_PINCH_IN  = 3'd2;
  localparam logic [2:0] GK_PINCH_OUT = 3'd3;
  localparam logic [2:0] GK_UP        = 3'd4;
  localparam logic [2:0] GK_DOWN      = 3'd5;
  localparam logic [2:0] GK_LEFT      = 3'd6;
  localparam logic [2:0] GK_RIGHT     = 3'd7;

  localparam logic [1:0] ERR_OK      = 2'd0;
  localparam logic [1:0] ERR_FULL    = 2'd1;
  localparam logic [1:0] ERR_UNKNOWN = 2'd2;

  localparam logic [0:0] REG_MOTION_THRESHOLD = 1'd0;
  localparam logic [0:0] REG_LONG_TAP_TIME    = 1'd1;

  localparam int unsigned PASS_LIMIT = 3;

  typedef struct packed {
    logic [1:0]         mode;
    logic [7:0]         contact_id;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [31:0]        stamp_ms;
  } tgc_in_t;

  typedef struct packed {
    logic       passthrough;
    logic       gesture_done;
    logic [2:0] gesture_kind;
    logic [4:0] finger_peak;
    logic [1:0] event_error;
  } tgc_out_t;

  typedef struct packed {
    logic [0:0]  index;
    logic [15:0] data;
  } tgc_cfg_t;
endpackage
`default_nettype wire

// ----- rtl/tgc_if.sv -----
// Valid/ready channel interfaces for the touch gesture classifier.
// Depends on tgc_pkg for payload types.
`default_nettype none
interface tgc_in_if import tgc_pkg::*; ();
  logic    valid;
  logic    ready;
  tgc_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tgc_out_if import tgc_pkg::*; ();
  logic     valid;
  logic     ready;
  tgc_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tgc_cfg_if import tgc_pkg::*; ();
  logic     valid;
  logic     ready;
  tgc_cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/tgc_isqrt.sv -----
// Shared distance unit: squares the deltas, then a bit-pair integer square root.
// Depends on tgc_pkg (none of its items beyond style); done pulses once the root is ready.
`default_nettype none
module tgc_isqrt import tgc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] xy_a,
  input  wire logic [31:0] xy_b,
  output logic             done,
  output logic [16:0]      root
);
  localparam logic [1:0] SQ_IDLE = 2'd0;
  localparam logic [1:0] SQ_MULX = 2'd1;
  localparam logic [1:0] SQ_MULY = 2'd2;
  localparam logic [1:0] SQ_ROOT = 2'd3;

  logic [1:0]  st_r, st_nxt;
  logic [16:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [33:0] v_r, v_nxt;
  logic [33:0] res_r, res_nxt;
  logic [4:0]  step_r, step_nxt;
  logic        done_r, done_nxt;
  logic signed [16:0] dxs, dys;
  logic [33:0] bitv, trial;

  always_comb begin
    dxs = $signed({xy_a[15], xy_a[15:0]}) - $signed({xy_b[15], xy_b[15:0]});
    dys = $signed({xy_a[31], xy_a[31:16]}) - $signed({xy_b[31], xy_b[31:16]});
    bitv = 34'd1 << {step_r, 1'b0};
    trial = res_r + bitv;
    st_nxt = st_r; dx_nxt = dx_r; dy_nxt = dy_r; v_nxt = v_r;
    res_nxt = res_r; step_nxt = step_r; done_nxt = 1'b0;
    unique case (st_r)
      SQ_IDLE: begin
        if (start) begin
          dx_nxt = dxs[16] ? 17'(-dxs) : 17'(dxs);
          dy_nxt = dys[16] ? 17'(-dys) : 17'(dys);
          st_nxt = SQ_MULX;
        end
      end
      SQ_MULX: begin
        v_nxt = 34'(dx_r * dx_r);
        st_nxt = SQ_MULY;
      end
      SQ_MULY: begin
        v_nxt = v_r + 34'(dy_r * dy_r);
        res_nxt = '0;
        step_nxt = 5'd16;
        st_nxt = SQ_ROOT;
      end
      SQ_ROOT: begin
        if (v_r >= trial) begin
          v_nxt = v_r - trial;
          res_nxt = (res_r >> 1) + bitv;
        end else begin
          res_nxt = res_r >> 1;
        end
        if (step_r == 5'd0) begin
          st_nxt = SQ_IDLE;
          done_nxt = 1'b1;
        end else begin
          step_nxt = step_r - 5'd1;
        end
      end
      default: st_nxt = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= SQ_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      done_r <= done_nxt;
    end
    dx_r <= dx_nxt; dy_r <= dy_nxt; v_r <= v_nxt; res_r <= res_nxt; step_r <= step_nxt;
  end

  assign done = done_r;
  assign root = res_r[16:0];
endmodule
`default_nettype wire

// ----- rtl/touch_gesture_classifier.sv -----
// Channel      | dir | payload
// in_          | in  | mode, contact_id, pos_x, pos_y, stamp_ms
// out_         | out | passthrough, gesture_done, gesture_kind, finger_peak, event_error
// cfg_         | in  | index (0 threshold, 1 long tap), data[15:0]
// Per item: a scan over all MAX_CONTACTS slots and a dispatch step, then the mode work;
// each distance goes through the shared square-root unit. Errors and up go straight to the
// result, down may compute one distance to the first finger; motion searches the slots
// for each rank, with one distance per pinch check and one for the swipe check.
// Synchronous active-low reset clears valid bits and gesture state.
// The result waits in the output register; the next item is taken the cycle after it leaves.
// Depends on tgc_pkg, tgc_if and tgc_isqrt.
`default_nettype none
module touch_gesture_classifier import tgc_pkg::*; #(
  parameter int MAX_CONTACTS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  tgc_in_if.sink    in_ch,
  tgc_out_if.source out_ch,
  tgc_cfg_if.sink   cfg_ch
);
  localparam int SW = $clog2(MAX_CONTACTS);
  localparam int CW = $clog2(MAX_CONTACTS + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_DISPATCH = 4'd2;
  localparam logic [3:0] S_DOWN_D = 4'd3;
  localparam logic [3:0] S_DOWN_W = 4'd4;
  localparam logic [3:0] S_UP     = 4'd5;
  localparam logic [3:0] S_RANK   = 4'd6;
  localparam logic [3:0] S_PINCH  = 4'd7;
  localparam logic [3:0] S_PINCH_W = 4'd8;
  localparam logic [3:0] S_SWIPE  = 4'd9;
  localparam logic [3:0] S_SWIPE_W = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;

  logic [MAX_CONTACTS-1:0] valid_r, valid_nxt;
  logic [7:0]  contact_r [MAX_CONTACTS];
  logic [31:0] start_r   [MAX_CONTACTS];
  logic [31:0] now_r     [MAX_CONTACTS];
  logic [31:0] dtime_r   [MAX_CONTACTS];
  logic [16:0] base_r    [MAX_CONTACTS];
  logic [SW-1:0] age_r   [MAX_CONTACTS];

  logic [7:0]  first_r, first_nxt;
  logic [CW-1:0] peak_r, peak_nxt;
  logic [2:0]  class_r, class_nxt;
  logic [15:0] thr_r, ltt_r;

  logic [3:0]  st_r, st_nxt;
  tgc_in_t     item_r, item_nxt;
  tgc_out_t    res_r, res_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] rank_r, rank_nxt;
  logic [SW:0] fbest_r, fbest_nxt, ibest_r, ibest_nxt;
  logic [SW:0] free_r, free_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] pslot_r, pslot_nxt;
  logic        pinch_r, pinch_nxt;

  logic        sq_start;
  logic [31:0] sq_a, sq_b;
  logic        sq_done;
  logic [16:0] sq_root;

  // write controls for the slot arrays
  logic        wr_new, wr_now, age_inc, age_dec;
  logic [SW-1:0] wslot;
  logic [SW-1:0] ci, fi, ii;
  logic [16:0] diff;
  logic        grow;
  logic signed [16:0] sdx, sdy;
  logic [16:0] ax, ay;

  tgc_isqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .xy_a(sq_a), .xy_b(sq_b),
    .done(sq_done), .root(sq_root)
  );

  assign in_ch.ready  = (st_r == S_IDLE) && !ovalid_r;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data  = res_r;

  always_comb begin
    ci = idx_r[SW-1:0];
    fi = fbest_r[SW-1:0];
    ii = ibest_r[SW-1:0];
    grow = sq_root > base_r[pslot_r];
    diff = grow ? sq_root - base_r[pslot_r] : base_r[pslot_r] - sq_root;
    sdx = $signed({now_r[fi][15], now_r[fi][15:0]}) - $signed({start_r[fi][15], start_r[fi][15:0]});
    sdy = $signed({now_r[fi][31], now_r[fi][31:16]}) -
          $signed({start_r[fi][31], start_r[fi][31:16]});
    ax = sdx[16] ? 17'(-sdx) : 17'(sdx);
    ay = sdy[16] ? 17'(-sdy) : 17'(sdy);

    st_nxt = st_r; item_nxt = item_r; res_nxt = res_r; ovalid_nxt = ovalid_r;
    idx_nxt = idx_r; rank_nxt = rank_r; fbest_nxt = fbest_r; ibest_nxt = ibest_r;
    free_nxt = free_r; cnt_nxt = cnt_r; pslot_nxt = pslot_r; pinch_nxt = pinch_r;
    valid_nxt = valid_r; first_nxt = first_r; peak_nxt = peak_r; class_nxt = class_r;
    sq_start = 1'b0; sq_a = '0; sq_b = '0;
    wr_new = 1'b0; wr_now = 1'b0; age_inc = 1'b0; age_dec = 1'b0; wslot = '0;

    if (out_ch.ready && ovalid_r) ovalid_nxt = 1'b0;

    unique case (st_r)
      S_IDLE: begin
        if (in_ch.valid && !ovalid_r) begin
          item_nxt = in_ch.data;
          res_nxt = '0;
          idx_nxt = '0; cnt_nxt = '0;
          fbest_nxt = '1; ibest_nxt = '1; free_nxt = '1;
          fbest_nxt[SW] = 1'b1; ibest_nxt[SW] = 1'b1; free_nxt[SW] = 1'b1;
          st_nxt = S_SCAN;
        end
      end
      // walk all slots: count, first free, newest slot of item id and of first id
      S_SCAN: begin
        if (valid_r[ci]) begin
          cnt_nxt = cnt_r + CW'(1);
          if (contact_r[ci] == item_r.contact_id &&
              (ibest_r[SW] || age_r[ci] < age_r[ii])) ibest_nxt = {1'b0, ci};
          if (contact_r[ci] == first_r &&
              (fbest_r[SW] || age_r[ci] < age_r[fi])) fbest_nxt = {1'b0, ci};
        end else if (free_r[SW]) begin
          free_nxt = {1'b0, ci};
        end
        if (idx_r == CW'(MAX_CONTACTS - 1)) st_nxt = S_DISPATCH;
        else idx_nxt = idx_r + CW'(1);
      end
      S_DISPATCH: begin
        unique case (item_r.mode)
          MODE_DOWN: begin
            if (free_r[SW]) begin
              res_nxt.passthrough = cnt_r < CW'(PASS_LIMIT);
              res_nxt.event_error = ERR_FULL;
              st_nxt = S_OUT;
            end else if (peak_r == '0 || fbest_r[SW]) begin
              st_nxt = S_DOWN_W;
              pslot_nxt = '0;
            end else begin
              st_nxt = S_DOWN_D;
              sq_start = 1'b1;
              sq_a = {item_r.pos_y, item_r.pos_x};
              sq_b = start_r[fi];
            end
          end
          MODE_UP: begin
            if (ibest_r[SW]) begin
              res_nxt.event_error = ERR_UNKNOWN;
              st_nxt = S_OUT;
            end else st_nxt = S_UP;
          end
          MODE_MOTION: begin
            res_nxt.passthrough = peak_r < CW'(PASS_LIMIT);
            if (ibest_r[SW]) begin
              res_nxt.event_error = ERR_UNKNOWN;
              st_nxt = S_OUT;
            end else begin
              wr_now = 1'b1; wslot = ii;
              if (fbest_r[SW]) st_nxt = S_OUT;
              else begin
                rank_nxt = '0; idx_nxt = '0; pinch_nxt = 1'b0;
                st_nxt = S_RANK;
              end
            end
          end
          default: st_nxt = S_OUT;
        endcase
      end
      S_DOWN_D: if (sq_done) st_nxt = S_DOWN_W;
      S_DOWN_W: begin
        if (peak_r == '0) first_nxt = item_r.contact_id;
        wr_new = 1'b1; age_inc = 1'b1; wslot = free_r[SW-1:0];
        valid_nxt[free_r[SW-1:0]] = 1'b1;
        if (cnt_r + CW'(1) > peak_r) peak_nxt = cnt_r + CW'(1);
        res_nxt.passthrough = (cnt_r + CW'(1)) < CW'(PASS_LIMIT);
        st_nxt = S_OUT;
      end
      S_UP: begin
        if (item_r.contact_id == first_r && class_r == GK_TAP &&
            (item_r.stamp_ms - dtime_r[ii]) > {16'd0, ltt_r}) class_nxt = GK_LONG_TAP;
        valid_nxt[ii] = 1'b0;
        age_dec = 1'b1; wslot = ii;
        if (cnt_r == CW'(1)) begin
          res_nxt.gesture_done = 1'b1;
          res_nxt.gesture_kind = (item_r.contact_id == first_r && class_r == GK_TAP &&
            (item_r.stamp_ms - dtime_r[ii]) > {16'd0, ltt_r}) ? GK_LONG_TAP : class_r;
          res_nxt.finger_peak = 5'(peak_r);
          peak_nxt = '0; class_nxt = GK_TAP;
        end
        st_nxt = S_OUT;
      end
      // find the slot of the current rank, newest first
      S_RANK: begin
        if (rank_r >= cnt_r) st_nxt = pinch_r ? S_OUT : S_SWIPE;
        else if (valid_r[ci] && CW'(age_r[ci]) == rank_r) begin
          idx_nxt = '0;
          rank_nxt = rank_r + CW'(1);
          if (contact_r[ci] != first_r) begin
            pslot_nxt = ci;
            sq_start = 1'b1; sq_a = now_r[ci]; sq_b = now_r[fi];
            st_nxt = S_PINCH_W;
          end
        end else if (idx_r == CW'(MAX_CONTACTS - 1)) begin
          idx_nxt = '0; rank_nxt = rank_r + CW'(1);
        end else idx_nxt = idx_r + CW'(1);
      end
      S_PINCH_W: begin
        if (sq_done) begin
          if (diff > {1'b0, thr_r}) begin
            class_nxt = grow ? GK_PINCH_OUT : GK_PINCH_IN;
            pinch_nxt = 1'b1;
            st_nxt = S_RANK;
          end else begin
            pinch_nxt = 1'b0;
            st_nxt = S_SWIPE;
          end
        end
      end
      S_SWIPE: begin
        sq_start = 1'b1; sq_a = start_r[fi]; sq_b = now_r[fi];
        st_nxt = S_SWIPE_W;
      end
      S_SWIPE_W: begin
        if (sq_done) begin
          if (sq_root > {1'b0, thr_r}) begin
            if (ax > ay) class_nxt = sdx[16] ? GK_LEFT : GK_RIGHT;
            else class_nxt = sdy[16] ? GK_UP : GK_DOWN;
          end
          st_nxt = S_OUT;
        end
      end
      S_OUT: begin
        ovalid_nxt = 1'b1;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ovalid_r <= 1'b0; valid_r <= '0;
      first_r <= '0; peak_r <= '0; class_r <= GK_TAP;
      thr_r <= 16'd0; ltt_r <= 16'd500;
    end else begin
      st_r <= st_nxt; ovalid_r <= ovalid_nxt; valid_r <= valid_nxt;
      first_r <= first_nxt; peak_r <= peak_nxt; class_r <= class_nxt;
      if (cfg_ch.valid) begin
        if (cfg_ch.data.index == REG_MOTION_THRESHOLD) thr_r <= cfg_ch.data.data;
        else ltt_r <= cfg_ch.data.data;
      end
    end
    item_r <= item_nxt; res_r <= res_nxt; idx_r <= idx_nxt; rank_r <= rank_nxt;
    fbest_r <= fbest_nxt; ibest_r <= ibest_nxt; free_r <= free_nxt; cnt_r <= cnt_nxt;
    pslot_r <= pslot_nxt; pinch_r <= pinch_nxt;
    for (int i = 0; i < MAX_CONTACTS; i++) begin
      if (age_inc && valid_r[i]) age_r[i] <= age_r[i] + SW'(1);
      if (age_dec && valid_r[i] && age_r[i] > age_r[wslot]) age_r[i] <= age_r[i] - SW'(1);
    end
    if (wr_new) begin
      contact_r[wslot] <= item_r.contact_id;
      start_r[wslot] <= {item_r.pos_y, item_r.pos_x};
      now_r[wslot] <= {item_r.pos_y, item_r.pos_x};
      dtime_r[wslot] <= item_r.stamp_ms;
      base_r[wslot] <= (peak_r == '0 || fbest_r[SW]) ? 17'd0 : sq_root;
      age_r[wslot] <= '0;
    end
    if (wr_now) now_r[wslot] <= {item_r.pos_y, item_r.pos_x};
  end
endmodule
`default_nettype wire

// ----- rtl/tgc_checker.sv -----
// Port-level checks for the touch gesture classifier, bound to the top level.
// Depends on tgc_pkg and the top level's channel interfaces.
`default_nettype none
module tgc_checker import tgc_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire tgc_out_t out_data
);
  // a report carries no other error and a nonzero peak
  a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.gesture_done |->
      out_data.event_error == ERR_OK && out_data.finger_peak != 5'd0)
    else $error("gesture report malformed");
  a_idle_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.gesture_done |-> out_data.gesture_kind == GK_TAP &&
      out_data.finger_peak == 5'd0)
    else $error("kind or peak set without report");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("item accepted while result pending");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted item");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped while stalled");
endmodule

bind touch_gesture_classifier tgc_checker u_tgc_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
`default_nettype wire

// ----- bench/tb_touch_gesture_classifier.sv -----
// Self-checking bench for touch_gesture_classifier: directed table, then random gesture traffic.
// Uses tgc_pkg types and the tgc_if channel interfaces; a cycle-free predictor scores random and unfixed results.
`default_nettype none
module tb_touch_gesture_classifier import tgc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 16;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    tgc_in_t  ev;
    bit       fixed;
    tgc_out_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tgc_in_if  in_ch();
  tgc_out_if out_ch();
  tgc_cfg_if cfg_ch();

  touch_gesture_classifier DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always #10 clk = ~clk;

  // tracked contact table
  bit          trk_valid [SLOTS];
  logic [7:0]  trk_id    [SLOTS];
  logic [31:0] trk_start [SLOTS];
  logic [31:0] trk_now   [SLOTS];
  logic [31:0] trk_t0    [SLOTS];
  logic [31:0] trk_base  [SLOTS];
  int          trk_age   [SLOTS];
  logic [7:0]  lead_id;
  int          peak_fingers;
  logic [2:0]  gesture_now;
  logic [15:0] thr_px;
  logic [15:0] long_ms;

  tgc_out_t expected_results[$];
  int       err_cnt = 0;
  int       sent_cnt = 0;
  int       idle_cycles = 0;
  bit       tx_quiet = 0;
  bit       rx_quiet = 0;
  bit       hold_rx = 0;
  int       rx_wait = 0;
  int       rx_seen = 0;
  logic [31:0] clock_ms = 0;
  dir_row_t rows[$];

  function automatic logic [31:0] root_floor(logic [63:0] v);
    logic [63:0] res, probe;
    res = 0;
    probe = 64'd1 << 36;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= res + probe) begin
        v = v - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res[31:0];
  endfunction

  function automatic logic [31:0] span(logic [31:0] a, logic [31:0] b);
    longint dx, dy;
    dx = longint'($signed(a[15:0])) - longint'($signed(b[15:0]));
    dy = longint'($signed(a[31:16])) - longint'($signed(b[31:16]));
    return root_floor(64'(dx * dx) + 64'(dy * dy));
  endfunction

  function automatic int live_count();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) n += trk_valid[i];
    return n;
  endfunction

  function automatic int slot_at_age(int rank);
    for (int i = 0; i < SLOTS; i++)
      if (trk_valid[i] && trk_age[i] == rank) return i;
    return -1;
  endfunction

  function automatic int newest_with_id(logic [7:0] id);
    int n, s;
    n = live_count();
    for (int r = 0; r < n; r++) begin
      s = slot_at_age(r);
      if (s >= 0 && trk_id[s] == id) return s;
    end
    return -1;
  endfunction

  function automatic void clear_gestures();
    for (int i = 0; i < SLOTS; i++) trk_valid[i] = 0;
    lead_id = 0;
    peak_fingers = 0;
    gesture_now = GK_TAP;
    thr_px = 0;
    long_ms = 16'd500;
  endfunction

  function automatic tgc_out_t classify(tgc_in_t ev);
    tgc_out_t o;
    logic [31:0] xy, base, cur, diff;
    int n, fr, s, f, p, age;
    bit pinch;
    longint dx, dy, ax, ay;
    o = '0;
    xy = {ev.pos_y, ev.pos_x};
    case (ev.mode)
      MODE_DOWN: begin
        n = live_count();
        fr = -1;
        for (int i = SLOTS - 1; i >= 0; i--) if (!trk_valid[i]) fr = i;
        if (fr < 0) begin
          o.passthrough = (n < PASS_LIMIT);
          o.event_error = ERR_FULL;
        end else begin
          base = 0;
          if (peak_fingers == 0) lead_id = ev.contact_id;
          else begin
            f = newest_with_id(lead_id);
            if (f >= 0) base = span(xy, trk_start[f]);
          end
          for (int i = 0; i < SLOTS; i++) if (trk_valid[i]) trk_age[i]++;
          trk_valid[fr] = 1;
          trk_id[fr] = ev.contact_id;
          trk_start[fr] = xy;
          trk_now[fr] = xy;
          trk_t0[fr] = ev.stamp_ms;
          trk_base[fr] = base;
          trk_age[fr] = 0;
          n++;
          if (n > peak_fingers) peak_fingers = n;
          o.passthrough = (n < PASS_LIMIT);
        end
      end
      MODE_UP: begin
        s = newest_with_id(ev.contact_id);
        if (s < 0) o.event_error = ERR_UNKNOWN;
        else begin
          if (ev.contact_id == lead_id && gesture_now == GK_TAP &&
              (ev.stamp_ms - trk_t0[s]) > {16'd0, long_ms})
            gesture_now = GK_LONG_TAP;
          age = trk_age[s];
          trk_valid[s] = 0;
          for (int i = 0; i < SLOTS; i++)
            if (trk_valid[i] && trk_age[i] > age) trk_age[i]--;
          if (live_count() == 0) begin
            o.gesture_done = 1;
            o.gesture_kind = gesture_now;
            o.finger_peak = 5'(peak_fingers);
            peak_fingers = 0;
            gesture_now = GK_TAP;
          end
        end
      end
      MODE_MOTION: begin
        o.passthrough = (peak_fingers < PASS_LIMIT);
        s = newest_with_id(ev.contact_id);
        if (s < 0) o.event_error = ERR_UNKNOWN;
        else begin
          trk_now[s] = xy;
          f = newest_with_id(lead_id);
          if (f >= 0) begin
            pinch = 0;
            n = live_count();
            for (int r = 0; r < n; r++) begin
              p = slot_at_age(r);
              if (p >= 0 && trk_id[p] != lead_id) begin
                cur = span(trk_now[p], trk_now[f]);
                diff = cur > trk_base[p] ? cur - trk_base[p] : trk_base[p] - cur;
                if (diff > {16'd0, thr_px}) begin
                  gesture_now = cur > trk_base[p] ? GK_PINCH_OUT : GK_PINCH_IN;
                  pinch = 1;
                end else begin
                  pinch = 0;
                  break;
                end
              end
            end
            if (!pinch && span(trk_start[f], trk_now[f]) > {16'd0, thr_px}) begin
              dx = longint'($signed(trk_now[f][15:0])) - longint'($signed(trk_start[f][15:0]));
              dy = longint'($signed(trk_now[f][31:16])) - longint'($signed(trk_start[f][31:16]));
              ax = dx < 0 ? -dx : dx;
              ay = dy < 0 ? -dy : dy;
              if (ax > ay) gesture_now = dx < 0 ? GK_LEFT : GK_RIGHT;
              else gesture_now = dy < 0 ? GK_UP : GK_DOWN;
            end
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_event(tgc_in_t ev, bit fixed = 0, tgc_out_t want = '0);
    int gap;
    tgc_out_t o;
    if (sent_cnt % 64 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
    gap = tx_quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= ev;
    do @(posedge clk); while (!in_ch.ready);
    o = classify(ev);
    expected_results.push_back(fixed ? want : o);
    sent_cnt++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    in_ch.valid <= 1'b0;
    wait (expected_results.size() == 0);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= '{index: idx, data: val};
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_MOTION_THRESHOLD) thr_px = val;
    else long_ms = val;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic tgc_in_t mk(logic [1:0] m, logic [7:0] id, int x, int y, logic [31:0] t);
    tgc_in_t ev;
    ev.mode = m;
    ev.contact_id = id;
    ev.pos_x = 16'(x);
    ev.pos_y = 16'(y);
    ev.stamp_ms = t;
    return ev;
  endfunction

  function automatic void add_row(tgc_in_t ev, bit fixed = 0, tgc_out_t want = '0);
    dir_row_t r;
    r.ev = ev;
    r.fixed = fixed;
    r.want = want;
    rows.push_back(r);
  endfunction

  function automatic tgc_out_t res(logic pt, logic dn, logic [2:0] k, int pk, logic [1:0] e);
    tgc_out_t o;
    o.passthrough = pt;
    o.gesture_done = dn;
    o.gesture_kind = k;
    o.finger_peak = 5'(pk);
    o.event_error = e;
    return o;
  endfunction

  function automatic logic [7:0] pick_live();
    logic [7:0] ids[$];
    for (int i = 0; i < SLOTS; i++) if (trk_valid[i]) ids.push_back(trk_id[i]);
    return ids[$urandom_range(0, ids.size() - 1)];
  endfunction

  function automatic logic [7:0] pick_stranger();
    logic [7:0] id;
    do id = 8'($urandom); while (newest_with_id(id) >= 0);
    return id;
  endfunction

  function automatic logic [31:0] tick();
    if ($urandom_range(0, 40) == 0) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(0, 900);
    return clock_ms;
  endfunction

  function automatic int coord(int center);
    if ($urandom_range(0, 30) == 0) return $urandom_range(0, 1) ? 32767 : -32768;
    return center + int'($urandom_range(0, 600)) - 300;
  endfunction

  task automatic run_gesture();
    int k, steps, cx, cy, r;
    k = ($urandom_range(0, 25) == 0) ? 17 : $urandom_range(1, 4);
    cx = $urandom_range(0, 7) == 0 ? int'($signed(16'($urandom))) : 0;
    cy = $urandom_range(0, 7) == 0 ? int'($signed(16'($urandom))) : 0;
    for (int i = 0; i < k; i++)
      send_event(mk(MODE_DOWN, 8'($urandom), coord(cx), coord(cy), tick()));
    steps = $urandom_range(0, 14);
    for (int i = 0; i < steps && live_count() > 0; i++) begin
      r = $urandom_range(0, 19);
      if (r < 12)
        send_event(mk(MODE_MOTION, pick_live(), coord(cx), coord(cy), $urandom));
      else if (r < 14)
        send_event(mk(MODE_DOWN, 8'($urandom), coord(cx), coord(cy), tick()));
      else if (r < 16 && live_count() > 1)
        send_event(mk(MODE_UP, pick_live(), $urandom, $urandom, tick()));
      else if (r == 16)
        send_event(mk(2'd3, 8'($urandom), $urandom, $urandom, $urandom));
      else if (r == 17)
        send_event(mk(MODE_MOTION, pick_stranger(), $urandom, $urandom, $urandom));
      else if (r == 18)
        send_event(mk(MODE_UP, pick_stranger(), $urandom, $urandom, tick()));
      else
        send_event(mk(MODE_DOWN, pick_live(), coord(cx), coord(cy), tick()));
    end
    while (live_count() > 0)
      send_event(mk(MODE_UP, pick_live(), $urandom, $urandom, tick()));
  endtask

  // result side: random stalls plus one long hold
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rx) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_rx = 0;
      end
      if (rx_wait > 0) begin
        out_ch.ready <= 1'b0;
        rx_wait--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    tgc_out_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_ch.data);
        err_cnt++;
      end else begin
        want = expected_results.pop_front();
        if (out_ch.data.passthrough !== want.passthrough) begin
          $display("%0t: passthrough expected %0d actual %0d", $time,
                   want.passthrough, out_ch.data.passthrough);
          err_cnt++;
        end
        if (out_ch.data.gesture_done !== want.gesture_done) begin
          $display("%0t: gesture_done expected %0d actual %0d", $time,
                   want.gesture_done, out_ch.data.gesture_done);
          err_cnt++;
        end
        if (out_ch.data.gesture_kind !== want.gesture_kind) begin
          $display("%0t: gesture_kind expected %0d actual %0d", $time,
                   want.gesture_kind, out_ch.data.gesture_kind);
          err_cnt++;
        end
        if (out_ch.data.finger_peak !== want.finger_peak) begin
          $display("%0t: finger_peak expected %0d actual %0d", $time,
                   want.finger_peak, out_ch.data.finger_peak);
          err_cnt++;
        end
        if (out_ch.data.event_error !== want.event_error) begin
          $display("%0t: event_error expected %0d actual %0d", $time,
                   want.event_error, out_ch.data.event_error);
          err_cnt++;
        end
      end
      rx_seen++;
      if (rx_seen % 50 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
      rx_wait = rx_quiet ? 0 : $urandom_range(0, 11);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [15:0] thr_set[4];
    logic [15:0] ltt_set[4];
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    clear_gestures();
    thr_set = '{16'd0, 16'd65535, 16'd40, 16'd3};
    ltt_set = '{16'd0, 16'd65535, 16'd300, 16'd1000};

    add_row(mk(MODE_DOWN, 8'd0, 0, 0, 100), 1, res(1, 0, GK_TAP, 0, ERR_OK));
    add_row(mk(MODE_UP, 8'd0, 0, 0, 200), 1, res(0, 1, GK_TAP, 1, ERR_OK));
    add_row(mk(MODE_UP, 8'd7, 0, 0, 300), 1, res(0, 0, GK_TAP, 0, ERR_UNKNOWN));
    add_row(mk(MODE_MOTION, 8'd7, 0, 0, 0), 1, res(1, 0, GK_TAP, 0, ERR_UNKNOWN));
    add_row(mk(2'd3, 8'd255, -1, -1, 32'hFFFF_FFFF), 1, res(0, 0, GK_TAP, 0, ERR_OK));
    add_row(mk(MODE_DOWN, 8'd255, -32768, 32767, 1000), 1, res(1, 0, GK_TAP, 0, ERR_OK));
    add_row(mk(MODE_MOTION, 8'd255, 32767, -32768, 0));
    add_row(mk(MODE_UP, 8'd255, 0, 0, 3000));
    add_row(mk(MODE_DOWN, 8'd1, 0, 0, 32'hFFFF_FF00), 1, res(1, 0, GK_TAP, 0, ERR_OK));
    // wraps past zero and still counts as held long
    add_row(mk(MODE_UP, 8'd1, 0, 0, 32'h0000_0300), 1, res(0, 1, GK_LONG_TAP, 1, ERR_OK));
    add_row(mk(MODE_DOWN, 8'd10, 100, 100, 0));
    add_row(mk(MODE_DOWN, 8'd20, 200, 100, 10));
    add_row(mk(MODE_DOWN, 8'd30, 100, 300, 20));
    add_row(mk(MODE_MOTION, 8'd20, 300, 100, 0));
    add_row(mk(MODE_MOTION, 8'd30, 100, 500, 0));
    add_row(mk(MODE_DOWN, 8'd20, 0, 0, 30));
    add_row(mk(MODE_UP, 8'd10, 0, 0, 50));
    add_row(mk(MODE_MOTION, 8'd20, 5, 5, 0));
    add_row(mk(MODE_DOWN, 8'd40, 7, 7, 60));
    add_row(mk(MODE_UP, 8'd20, 0, 0, 70));
    add_row(mk(MODE_UP, 8'd20, 0, 0, 80));
    add_row(mk(MODE_UP, 8'd30, 0, 0, 90));
    add_row(mk(MODE_UP, 8'd40, 0, 0, 100));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i]) send_event(rows[i].ev, rows[i].fixed, rows[i].want);

    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        write_reg(REG_MOTION_THRESHOLD, ph == 4 ? 16'($urandom_range(0, 200)) : thr_set[ph - 1]);
        write_reg(REG_LONG_TAP_TIME, ph == 4 ? 16'($urandom) : ltt_set[ph - 1]);
      end
      // stall the result side while items keep coming
      if (ph == 2) hold_rx = 1;
      while (sent_cnt < 23 + (ph + 1) * 360) run_gesture();
    end
    in_ch.valid <= 1'b0;

    wait (expected_results.size() == 0);
    repeat (500) @(posedge clk);
    if (err_cnt == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire
